// ----- rtl/igtm_pkg.sv -----
package igtm_pkg;

	localparam int unsigned NumAxes     = 6;
	localparam int unsigned AxisW       = 24;
	localparam logic [15:0] FiltCoef    = 16'd13107;
	localparam logic [15:0] ShakeLevel  = 16'd1600;
	localparam logic [9:0]  MinHz       = 10'd220;
	localparam logic [9:0]  SpanHz      = 10'd660;
	localparam logic [9:0]  MidHz       = 10'd550;

	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_START = 2'd1,
		ACT_STOP  = 2'd2
	} tone_act_t;

	typedef enum logic [1:0] {
		MODE_NOTES = 2'd0,
		MODE_PERC  = 2'd1,
		MODE_TRIAD = 2'd2,
		MODE_CONT  = 2'd3
	} synth_mode_t;

	typedef enum logic [3:0] {
		G_NONE    = 4'd0,
		G_PUNCH   = 4'd1,
		G_SHAKE_X = 4'd2,
		G_SHAKE_Y = 4'd3,
		G_SHAKE_Z = 4'd4,
		G_RIGHT   = 4'd5,
		G_LEFT    = 4'd6,
		G_BACK    = 4'd7,
		G_FWD     = 4'd8
	} gesture_t;

	typedef enum logic [2:0] {
		REG_MODE   = 3'd0,
		REG_ENABLE = 3'd1,
		REG_HIGH   = 3'd2,
		REG_MED    = 3'd3,
		REG_LOW    = 3'd4,
		REG_DEB    = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILT,
		ST_CLASS,
		ST_DIV,
		ST_DONE
	} state_t;

	function automatic logic [9:0] note_hz(input logic [3:0] g);
		case (g)
			G_PUNCH:   note_hz = 10'd880;
			G_SHAKE_X: note_hz = 10'd659;
			G_SHAKE_Y: note_hz = 10'd740;
			G_SHAKE_Z: note_hz = 10'd831;
			G_RIGHT:   note_hz = 10'd494;
			G_LEFT:    note_hz = 10'd440;
			G_BACK:    note_hz = 10'd587;
			G_FWD:     note_hz = 10'd554;
			default:   note_hz = 10'd0;
		endcase
	endfunction

endpackage

// ----- rtl/igtm_div.sv -----
module igtm_div
	import igtm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [25:0] dividend,
	input  logic [15:0] divisor,
	output logic        busy,
	output logic        done,
	output logic [9:0]  quotient
);

	logic [15:0] rem_q;
	logic [25:0] quo_q;
	logic [15:0] dvs_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] trial;
	logic [16:0] part;

	assign part  = {rem_q, quo_q[25]};
	assign trial = part - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd26;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[16]) begin
				rem_q <= trial[15:0];
				quo_q <= {quo_q[24:0], 1'b1};
			end else begin
				rem_q <= part[15:0];
				quo_q <= {quo_q[24:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q[9:0];

endmodule

// ----- rtl/imu_gesture_tone_mapper_core.sv -----
// Gesture tone mapper: each IMU sample passes one multiplier over six filter
// channels, one channel after another, and is then classified; in continuous
// mode, with no gesture, the pitch can come from a restoring divider. The result
// is held in the output registers until it is taken; the next sample is accepted
// only once the previous result has been taken.
module imu_gesture_tone_mapper_core
	import igtm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] gyro_x,
	input  logic signed [15:0] gyro_y,
	input  logic signed [15:0] gyro_z,
	input  logic [31:0]        now_ms,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         tone_action,
	output logic [9:0]         tone_hz,
	output logic [6:0]         pulse_ms,
	output logic [3:0]         gesture_code,
	output logic [9:0]         sounding_hz
);

	logic [1:0]  mode_q;
	logic        en_q;
	logic [14:0] th_q, tm_q, tl_q;
	logic [15:0] deb_q;

	logic signed [AxisW-1:0] axes_q [NumAxes];
	logic [31:0] last_time_q;
	logic [3:0]  last_g_q;
	logic [9:0]  cur_hz_q;

	logic signed [15:0] x_q [NumAxes];
	logic signed [15:0] f_q [NumAxes];
	logic [31:0] now_q;
	logic [2:0]  idx_q;

	state_t state_q, state_d;

	logic        wr_en;
	logic [2:0]  widx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign widx   = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NOTES;
			en_q   <= 1'b1;
			th_q   <= 15'd6144;
			tm_q   <= 15'd2048;
			tl_q   <= 15'd819;
			deb_q  <= 16'd200;
		end else if (wr_en) begin
			case (widx)
				REG_MODE:   mode_q <= pwdata[1:0];
				REG_ENABLE: en_q   <= pwdata[0];
				REG_HIGH:   th_q   <= pwdata[14:0];
				REG_MED:    tm_q   <= pwdata[14:0];
				REG_LOW:    tl_q   <= pwdata[14:0];
				REG_DEB:    deb_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_MODE:   prdata = {30'd0, mode_q};
			REG_ENABLE: prdata = {31'd0, en_q};
			REG_HIGH:   prdata = {17'd0, th_q};
			REG_MED:    prdata = {17'd0, tm_q};
			REG_LOW:    prdata = {17'd0, tl_q};
			REG_DEB:    prdata = {16'd0, deb_q};
			default:    prdata = '0;
		endcase
	end

	// Shared filter multiplier: one channel per cycle.
	logic signed [AxisW:0]   diff;
	logic signed [AxisW+16:0] prod;
	logic signed [AxisW-1:0] s_new;

	assign diff  = {x_q[idx_q][15], x_q[idx_q], 8'd0} - {axes_q[idx_q][AxisW-1], axes_q[idx_q]};
	assign prod  = diff * $signed({1'b0, FiltCoef});
	assign s_new = axes_q[idx_q] + AxisW'(prod >>> 16);

	// Classification.
	logic        deb_ok;
	logic [31:0] elapsed;
	logic [3:0]  g_d;
	logic signed [16:0] thx, tmx, tlx, shk;
	logic signed [16:0] fx, fy, fz, gx, gy, gz;

	assign elapsed = now_q - last_time_q;
	assign deb_ok  = elapsed >= {16'd0, deb_q};
	assign thx = {2'b00, th_q};
	assign tmx = {2'b00, tm_q};
	assign tlx = {2'b00, tl_q};
	assign shk = {1'b0, ShakeLevel};
	assign fx  = 17'(f_q[0]);
	assign fy  = 17'(f_q[1]);
	assign fz  = 17'(f_q[2]);
	assign gx  = 17'(f_q[3]);
	assign gy  = 17'(f_q[4]);
	assign gz  = 17'(f_q[5]);

	always_comb begin
		g_d = G_NONE;
		if (deb_ok) begin
			if (fz > thx) g_d = G_PUNCH;
			else if (gx > shk || gx < -shk) g_d = G_SHAKE_X;
			else if (gy > shk || gy < -shk) g_d = G_SHAKE_Y;
			else if (gz > shk || gz < -shk) g_d = G_SHAKE_Z;
			else if (fx < -tmx) g_d = G_RIGHT;
			else if (fx > tmx) g_d = G_LEFT;
			else if (fy < -tmx) g_d = G_BACK;
			else if (fy > tmx) g_d = G_FWD;
		end
	end

	logic        cont_on;
	logic signed [16:0] clamp;
	logic [16:0] cplus;
	logic [25:0] dividend;
	logic [15:0] divisor;
	logic        div_start;
	logic        div_busy;
	logic        div_done;
	logic [9:0]  quo;

	assign cont_on = en_q && (fx > tlx || fx < -tlx);
	always_comb begin
		clamp = fx;
		if (fx < -thx) clamp = -thx;
		if (fx > thx)  clamp = thx;
	end
	assign cplus    = 17'(clamp + thx);
	assign dividend = {10'd0, cplus[15:0]} * {16'd0, SpanHz};
	assign divisor  = {th_q, 1'b0};

	igtm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quo)
	);

	logic in_acc;
	assign in_acc  = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);

	logic need_div;
	assign need_div = (g_d == G_NONE) && (mode_q == MODE_CONT) && cont_on && (th_q != 15'd0);

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_FILT;
			ST_FILT:  if (idx_q == 3'(NumAxes - 1)) state_d = ST_CLASS;
			ST_CLASS: begin
				if (need_div) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DIV:   if (div_done) state_d = ST_DONE;
			ST_DONE:  if (out_ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			last_time_q <= '0;
			last_g_q    <= G_NONE;
			cur_hz_q    <= '0;
			tone_action <= ACT_NONE;
			tone_hz     <= '0;
			pulse_ms    <= '0;
			gesture_code <= G_NONE;
			for (int i = 0; i < NumAxes; i++) axes_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FILT) begin
				axes_q[idx_q] <= s_new;
				idx_q <= (idx_q == 3'(NumAxes - 1)) ? 3'd0 : idx_q + 3'd1;
			end
			if (state_q == ST_CLASS) begin
				gesture_code <= g_d;
				tone_action  <= ACT_NONE;
				tone_hz      <= '0;
				pulse_ms     <= '0;
				if (g_d != G_NONE) begin
					last_g_q    <= g_d;
					last_time_q <= now_q;
					if (en_q) begin
						case (mode_q)
							MODE_NOTES: begin
								tone_action <= ACT_START;
								tone_hz     <= note_hz(g_d);
								cur_hz_q    <= note_hz(g_d);
							end
							MODE_PERC: begin
								case (g_d)
									G_LEFT: begin
										tone_action <= ACT_START; tone_hz <= 10'd150;
										pulse_ms <= 7'd50; cur_hz_q <= '0;
									end
									G_RIGHT: begin
										tone_action <= ACT_START; tone_hz <= 10'd200;
										pulse_ms <= 7'd50; cur_hz_q <= '0;
									end
									G_SHAKE_X, G_SHAKE_Y, G_SHAKE_Z: begin
										tone_action <= ACT_START; tone_hz <= 10'd800;
										pulse_ms <= 7'd30; cur_hz_q <= '0;
									end
									G_PUNCH: begin
										tone_action <= ACT_START; tone_hz <= 10'd100;
										pulse_ms <= 7'd100; cur_hz_q <= '0;
									end
									default: ;
								endcase
							end
							MODE_TRIAD: begin
								case (g_d)
									G_LEFT: begin
										tone_action <= ACT_START; tone_hz <= 10'd440;
										cur_hz_q <= 10'd440;
									end
									G_RIGHT: begin
										tone_action <= ACT_START; tone_hz <= 10'd659;
										cur_hz_q <= 10'd659;
									end
									G_FWD: begin
										tone_action <= ACT_START; tone_hz <= 10'd587;
										cur_hz_q <= 10'd587;
									end
									G_BACK: begin
										tone_action <= ACT_START; tone_hz <= 10'd880;
										cur_hz_q <= 10'd880;
									end
									default: begin
										tone_action <= ACT_STOP; cur_hz_q <= '0;
									end
								endcase
							end
							default: ;
						endcase
					end
				end else if (mode_q == MODE_CONT) begin
					if (cont_on && th_q == 15'd0) begin
						tone_action <= ACT_START;
						tone_hz     <= MidHz;
						cur_hz_q    <= MidHz;
					end else if (!cont_on) begin
						tone_action <= ACT_STOP;
						cur_hz_q    <= '0;
					end
				end
			end
			if (state_q == ST_DIV && div_done) begin
				tone_action <= ACT_START;
				tone_hz     <= MinHz + quo;
				cur_hz_q    <= MinHz + quo;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q[0] <= accel_x;
			x_q[1] <= accel_y;
			x_q[2] <= accel_z;
			x_q[3] <= gyro_x;
			x_q[4] <= gyro_y;
			x_q[5] <= gyro_z;
			now_q  <= now_ms;
		end
		if (state_q == ST_FILT) f_q[idx_q] <= s_new[23:8];
	end

	assign out_valid   = (state_q == ST_DONE);
	assign sounding_hz = cur_hz_q;

`ifndef NO_ASSERTIONS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("ready while result pending");
	a_div_only: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == ST_DIV) else $error("divider busy outside divide");
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tone_hz))
		else $error("result lost");
	a_gesture: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> gesture_code <= G_FWD) else $error("gesture code out of range");
`endif

endmodule
